// ----- rtl/kwm_pkg.sv -----
// Shared constants and types for the sorted k-way merge with duplicate removal.
package kwm_pkg;

  localparam int unsigned MAX_STREAMS_DEF = 256;
  localparam int unsigned DOC_BITS        = 32;
  localparam int unsigned SIDX_BITS       = 8;
  localparam int unsigned CFG_BITS        = 9;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_INSERT,
    OP_REPLACE,
    OP_DELETE
  } op_e;

endpackage

// ----- rtl/kway_sorted_merge_dedup.sv -----
// Top level of the sorted k-way merge with duplicate removal over a sorted cell chain.
// An accepted word updates the whole cell chain at its accepting edge. A refill word or the last
// load word also sets a pending flag, and its result word is then registered on the output.
// The pending flag holds the input off until that result word is formed, so no word is taken
// behind it before then; other words are taken back to back. An untaken result word
// stalls the input only once the next result is ready. Reset and a configuration write restart.
module kway_sorted_merge_dedup #(
  parameter int unsigned MAX_STREAMS = kwm_pkg::MAX_STREAMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kwm_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,  // stream_index[7:0], head_doc[39:8]
  input  logic                         s_axis_tuser,  // stream_ended
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // out_doc[31:0], fetch_stream[39:32]
  output logic [2:0]                   m_axis_tuser   // emit_valid, fetch_valid, finished
);

  localparam int unsigned IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int unsigned CW = $clog2(MAX_STREAMS + 1);
  localparam int unsigned DW = kwm_pkg::DOC_BITS;

  logic [kwm_pkg::CFG_BITS-1:0] active_q;
  logic [CW-1:0]                cnt_q, cnt_d, loaded_q, loaded_d, eff;
  logic [DW-1:0]                last_q, last_d;
  logic                         any_q, any_d, pend_q, pend_d;
  logic                         mv_q, mv_d;
  logic [39:0]                  mdata_q, mdata_d;
  logic [2:0]                   muser_q, muser_d;
  kwm_pkg::op_e                 op;
  logic [IW-1:0]                new_idx;

  logic                         c_valid [MAX_STREAMS];
  logic [DW-1:0]                c_doc   [MAX_STREAMS];
  logic [IW-1:0]                c_idx   [MAX_STREAMS];
  logic                         c_lt    [MAX_STREAMS];

  logic [7:0]    in_sidx;
  logic [DW-1:0] in_doc;
  logic          in_ended, accept, loading, form;

  assign in_sidx  = s_axis_tdata[7:0];
  assign in_doc   = s_axis_tdata[39:8];
  assign in_ended = s_axis_tuser;
  assign s_axis_tready = !pend_q;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign loading  = loaded_q < eff;
  assign form     = pend_q && (!mv_q || m_axis_tready);

  always_comb begin
    if (active_q == '0) begin
      eff = CW'(1);
    end else if (32'(active_q) > MAX_STREAMS) begin
      eff = CW'(MAX_STREAMS);
    end else begin
      eff = CW'(active_q);
    end
  end

  always_comb begin
    op       = kwm_pkg::OP_HOLD;
    new_idx  = IW'(loaded_q);
    cnt_d    = cnt_q;
    loaded_d = loaded_q;
    pend_d   = pend_q && !form;
    last_d   = last_q;
    any_d    = any_q;
    mv_d     = mv_q && !m_axis_tready;
    mdata_d  = mdata_q;
    muser_d  = muser_q;
    if (form) begin
      mv_d = 1'b1;
      if (cnt_q == '0) begin
        mdata_d = '0;
        muser_d = 3'b100;
      end else begin
        mdata_d = {8'(c_idx[0]), c_doc[0]};
        if (!any_q || c_doc[0] != last_q) begin
          muser_d = 3'b011;
          last_d  = c_doc[0];
          any_d   = 1'b1;
        end else begin
          muser_d = 3'b010;
        end
      end
    end
    if (cfg_we_i) begin
      op       = kwm_pkg::OP_CLEAR;
      cnt_d    = '0;
      loaded_d = '0;
      last_d   = '0;
      any_d    = 1'b0;
    end else if (accept) begin
      if (loading) begin
        loaded_d = loaded_q + CW'(1);
        if (!in_ended) begin
          op    = kwm_pkg::OP_INSERT;
          cnt_d = cnt_q + CW'(1);
        end
        if (loaded_d == eff) begin
          pend_d = 1'b1;
        end
      end else if (cnt_q != '0 && 8'(c_idx[0]) == in_sidx) begin
        new_idx = c_idx[0];
        pend_d  = 1'b1;
        if (in_ended) begin
          op    = kwm_pkg::OP_DELETE;
          cnt_d = cnt_q - CW'(1);
        end else begin
          op    = kwm_pkg::OP_REPLACE;
        end
      end
    end
  end

  for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_cell
    logic          lv, ll, rv, rl;
    logic [DW-1:0] ld, rd;
    logic [IW-1:0] li, ri;
    if (i == 0) begin : g_l0
      assign lv = 1'b0;
      assign ll = 1'b0;
      assign ld = '0;
      assign li = '0;
    end else begin : g_ln
      assign lv = c_valid[i-1];
      assign ll = c_lt[i-1];
      assign ld = c_doc[i-1];
      assign li = c_idx[i-1];
    end
    if (i == MAX_STREAMS - 1) begin : g_rl
      assign rv = 1'b0;
      assign rl = 1'b1;
      assign rd = '0;
      assign ri = '0;
    end else begin : g_rn
      assign rv = c_valid[i+1];
      assign rl = c_lt[i+1];
      assign rd = c_doc[i+1];
      assign ri = c_idx[i+1];
    end
    kwm_cell #(
      .IW   (IW),
      .FIRST(i == 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .new_doc_i    (in_doc),
      .new_idx_i    (new_idx),
      .left_valid_i (lv),
      .left_doc_i   (ld),
      .left_idx_i   (li),
      .left_lt_i    (ll),
      .right_valid_i(rv),
      .right_doc_i  (rd),
      .right_idx_i  (ri),
      .right_lt_i   (rl),
      .valid_o      (c_valid[i]),
      .doc_o        (c_doc[i]),
      .idx_o        (c_idx[i]),
      .lt_o         (c_lt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= kwm_pkg::CFG_BITS'(1);
      cnt_q    <= '0;
      loaded_q <= '0;
      last_q   <= '0;
      any_q    <= 1'b0;
      pend_q   <= 1'b0;
      mv_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      loaded_q <= loaded_d;
      last_q   <= last_d;
      any_q    <= any_d;
      pend_q   <= pend_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_STREAMS) else $error("entry count exceeds chain length");
  a_root_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) == c_valid[0]) else $error("root cell validity disagrees with count");
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(loaded_q) <= MAX_STREAMS) else $error("load counter out of range");

endmodule

// ----- rtl/kwm_cell.sv -----
// One cell of the sorted entry chain: holds one (id, stream) entry and shifts with its neighbours.
module kwm_cell #(
  parameter int unsigned IW    = 8,
  parameter bit          FIRST = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kwm_pkg::op_e                 op_i,
  input  logic [kwm_pkg::DOC_BITS-1:0] new_doc_i,
  input  logic [IW-1:0]                new_idx_i,
  input  logic                         left_valid_i,
  input  logic [kwm_pkg::DOC_BITS-1:0] left_doc_i,
  input  logic [IW-1:0]                left_idx_i,
  input  logic                         left_lt_i,
  input  logic                         right_valid_i,
  input  logic [kwm_pkg::DOC_BITS-1:0] right_doc_i,
  input  logic [IW-1:0]                right_idx_i,
  input  logic                         right_lt_i,
  output logic                         valid_o,
  output logic [kwm_pkg::DOC_BITS-1:0] doc_o,
  output logic [IW-1:0]                idx_o,
  output logic                         lt_o
);

  logic                         valid_q, valid_d;
  logic [kwm_pkg::DOC_BITS-1:0] doc_q, doc_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic                         lt;

  // An empty cell counts as larger than any entry.
  assign lt = !valid_q || (new_doc_i < doc_q) || ((new_doc_i == doc_q) && (new_idx_i < idx_q));

  always_comb begin
    valid_d = valid_q;
    doc_d   = doc_q;
    idx_d   = idx_q;
    case (op_i)
      kwm_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      kwm_pkg::OP_INSERT: begin
        if (lt) begin
          if (left_lt_i) begin
            valid_d = left_valid_i;
            doc_d   = left_doc_i;
            idx_d   = left_idx_i;
          end else begin
            valid_d = 1'b1;
            doc_d   = new_doc_i;
            idx_d   = new_idx_i;
          end
        end
      end
      kwm_pkg::OP_REPLACE: begin
        if (right_lt_i) begin
          if (!(lt && !FIRST)) begin
            valid_d = 1'b1;
            doc_d   = new_doc_i;
            idx_d   = new_idx_i;
          end
        end else begin
          valid_d = right_valid_i;
          doc_d   = right_doc_i;
          idx_d   = right_idx_i;
        end
      end
      kwm_pkg::OP_DELETE: begin
        valid_d = right_valid_i;
        doc_d   = right_doc_i;
        idx_d   = right_idx_i;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    doc_q <= doc_d;
    idx_q <= idx_d;
  end

  assign valid_o = valid_q;
  assign doc_o   = doc_q;
  assign idx_o   = idx_q;
  assign lt_o    = lt;

endmodule
